FILE: hw/rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, register group codes and constants of the bank switch mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // register groups, cpu address bits 15..12
  localparam logic [3:0] BANK_PRG0     = 4'h8;
  localparam logic [3:0] BANK_MIRROR   = 4'h9;
  localparam logic [3:0] BANK_PRG1     = 4'hA;
  localparam logic [3:0] BANK_CHR_LO   = 4'hB;
  localparam logic [3:0] BANK_CHR_HI   = 4'hE;
  localparam logic [3:0] BANK_IRQ      = 4'hF;

  // register index inside the irq group
  localparam logic [1:0] IDX_LATCH_LO  = 2'd0;
  localparam logic [1:0] IDX_LATCH_HI  = 2'd1;
  localparam logic [1:0] IDX_CTRL      = 2'd2;
  localparam logic [1:0] IDX_ACK       = 2'd3;

  // irq control bits
  localparam int unsigned CTRL_ACK_EN  = 0;
  localparam int unsigned CTRL_EN      = 1;
  localparam int unsigned CTRL_CYCLE   = 2;

  localparam logic [9:0] PRESCALE_RELOAD = 10'd341;
  localparam logic [9:0] PRESCALE_STEP   = 10'd3;
  localparam logic [9:0] PRESCALE_WRAP   = PRESCALE_RELOAD - PRESCALE_STEP;
  localparam logic [4:0] FIXED_BANK      = 5'h1E;
  localparam logic [7:0] COUNTER_MAX     = 8'hFF;
  localparam int unsigned NUM_CHR        = 8;

  typedef struct packed {
    op_e        op;
    logic [3:0] bank;
    logic [1:0] idx;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [3:0]                 prg0;
    logic [3:0]                 prg1;
    logic                       swap;
    logic [1:0]                 mirror;
    logic [NUM_CHR-1:0][7:0]    chr;
  } bank_map_t;

  // register index from the window offset: bit pairs ored together
  function automatic logic [1:0] reg_index(input logic [11:0] off);
    reg_index = off[1:0] | off[3:2] | off[5:4] | off[7:6];
  endfunction

endpackage

FILE: hw/rtl/bank_switch_mapper_with_irq_counter.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_irq_counter
// Bank switching mapper with irq counter: input register, register update,
// result register.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  in      | in_valid_i/in_ready_o | opcode_i bank_i offset_i value_i
//  out     | out_valid_o/out_ready_i | irq_line_o prg_bank_*_o chr_banks_*_o mirroring_o
//
//  one word per cycle sustained while the output is not stalled; a word
//  goes from the input register through the state update into the result register
//  state registers update as the word leaves the input register
//  reset restores bank map and clears irq state; no clearing pass
//  an output stall holds the result; the input register still takes a word
//  when it is empty
module bank_switch_mapper_with_irq_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [3:0]  bank_i,
  input  logic [11:0] offset_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        irq_line_o,
  output logic [4:0]  prg_bank_8000_o,
  output logic [3:0]  prg_bank_a000_o,
  output logic [4:0]  prg_bank_c000_o,
  output logic [31:0] chr_banks_low_o,
  output logic [31:0] chr_banks_high_o,
  output logic [1:0]  mirroring_o
);
  import bsm_pkg::*;

  logic      in_vld_q;
  item_t     in_item_q;
  logic      out_vld_q;
  logic      irq_q;
  bank_map_t map_q;
  logic      advance;
  logic      fire;
  logic      pend_d;
  bank_map_t map_d;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q.op    <= op_e'(opcode_i);
      in_item_q.bank  <= bank_i;
      in_item_q.idx   <= reg_index(offset_i);
      in_item_q.value <= value_i;
    end
    if (fire) begin
      irq_q <= pend_d;
      map_q <= map_d;
    end
  end

  bsm_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .item_i  (in_item_q),
    .map_d_o (map_d)
  );

  bsm_irq u_irq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (fire),
    .item_i      (in_item_q),
    .pending_d_o (pend_d)
  );

  assign out_valid_o      = out_vld_q;
  assign irq_line_o       = irq_q;
  assign prg_bank_8000_o  = map_q.swap ? FIXED_BANK : {1'b0, map_q.prg0};
  assign prg_bank_a000_o  = map_q.prg1;
  assign prg_bank_c000_o  = map_q.swap ? {1'b0, map_q.prg0} : FIXED_BANK;
  assign chr_banks_low_o  = map_q.chr[3:0];
  assign chr_banks_high_o = map_q.chr[7:4];
  assign mirroring_o      = map_q.mirror;

endmodule

FILE: hw/rtl/bsm_bank.sv
// ----------------------------------------------------------------------------
// bsm_bank
// Program, character, swap and mirroring registers with their write decode.
// ----------------------------------------------------------------------------
module bsm_bank (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  bsm_pkg::item_t    item_i,
  output bsm_pkg::bank_map_t map_d_o
);
  import bsm_pkg::*;

  bank_map_t  map_q;
  bank_map_t  map_d;
  logic [3:0] chr_grp;
  logic [2:0] chr_sel;

  assign chr_grp = item_i.bank - BANK_CHR_LO;
  assign chr_sel = {chr_grp[1:0], item_i.idx[1]};

  always_comb begin
    map_d = map_q;
    if (en_i && item_i.op == OP_WRITE) begin
      if (item_i.bank inside {[BANK_CHR_LO:BANK_CHR_HI]}) begin
        if (item_i.idx[0]) begin
          map_d.chr[chr_sel][7:4] = item_i.value[3:0];
        end else begin
          map_d.chr[chr_sel][3:0] = item_i.value[3:0];
        end
      end else begin
        case (item_i.bank)
          BANK_PRG0: map_d.prg0 = item_i.value[3:0];
          BANK_PRG1: map_d.prg1 = item_i.value[3:0];
          BANK_MIRROR: begin
            if (item_i.idx[1]) begin
              map_d.swap = item_i.value[1];
            end else begin
              map_d.mirror = item_i.value[1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q.prg0   <= 4'd0;
      map_q.prg1   <= 4'd1;
      map_q.swap   <= 1'b0;
      map_q.mirror <= 2'd0;
      for (int i = 0; i < NUM_CHR; i++) begin
        map_q.chr[i] <= 8'(i);
      end
    end else begin
      map_q <= map_d;
    end
  end

  assign map_d_o = map_d;

endmodule

FILE: hw/rtl/bsm_irq.sv
// ----------------------------------------------------------------------------
// bsm_irq
// IRQ latch, control, prescaler and up counter with pending flag.
// ----------------------------------------------------------------------------
module bsm_irq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  bsm_pkg::item_t item_i,
  output logic           pending_d_o
);
  import bsm_pkg::*;

  logic [7:0] latch_q, latch_d;
  logic [7:0] cnt_q, cnt_d;
  logic [2:0] ctrl_q, ctrl_d;
  logic [9:0] presc_q, presc_d;
  logic       pend_q, pend_d;
  logic       presc_wrap;
  logic       step;

  assign presc_wrap = presc_q < PRESCALE_STEP;

  always_comb begin
    latch_d = latch_q;
    cnt_d   = cnt_q;
    ctrl_d  = ctrl_q;
    presc_d = presc_q;
    pend_d  = pend_q;
    step    = 1'b0;
    if (en_i) begin
      if (item_i.op == OP_TICK) begin
        if (ctrl_q[CTRL_EN]) begin
          if (ctrl_q[CTRL_CYCLE]) begin
            step = 1'b1;
          end else begin
            step    = presc_wrap;
            presc_d = presc_wrap ? presc_q + PRESCALE_WRAP : presc_q - PRESCALE_STEP;
          end
        end
        if (step) begin
          if (cnt_q == COUNTER_MAX) begin
            cnt_d  = latch_q;
            pend_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end
      end else if (item_i.bank == BANK_IRQ) begin
        case (item_i.idx)
          IDX_LATCH_LO: latch_d[3:0] = item_i.value[3:0];
          IDX_LATCH_HI: latch_d[7:4] = item_i.value[3:0];
          IDX_CTRL: begin
            ctrl_d = item_i.value[2:0];
            if (item_i.value[CTRL_EN]) begin
              cnt_d   = latch_q;
              presc_d = PRESCALE_RELOAD;
            end
            pend_d = 1'b0;
          end
          IDX_ACK: begin
            ctrl_d[CTRL_EN] = ctrl_q[CTRL_ACK_EN];
            pend_d          = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      cnt_q   <= '0;
      ctrl_q  <= '0;
      presc_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      latch_q <= latch_d;
      cnt_q   <= cnt_d;
      ctrl_q  <= ctrl_d;
      presc_q <= presc_d;
      pend_q  <= pend_d;
    end
  end

  assign pending_d_o = pend_d;

endmodule

FILE: hw/rtl/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// Port level checks of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
module bsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        irq_line_o,
  input logic [4:0]  prg_bank_8000_o,
  input logic [4:0]  prg_bank_c000_o,
  input logic [31:0] chr_banks_low_o,
  input logic [31:0] chr_banks_high_o
);
  import bsm_pkg::*;

  // a held result stays valid and keeps its irq line and character banks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(irq_line_o)
      && $stable(chr_banks_low_o) && $stable(chr_banks_high_o))
    else $error("result word changed while stalled");

  // input side only backs up behind a full result register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

  // exactly one of the swappable windows shows the fixed bank
  a_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prg_bank_8000_o == FIXED_BANK) != (prg_bank_c000_o == FIXED_BANK))
    else $error("fixed bank mapping broken");

  // bank registers are four bits, so the top bit only comes from the fixed bank
  a_prg_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (prg_bank_8000_o[4] || prg_bank_c000_o[4]) |->
      (prg_bank_8000_o == FIXED_BANK) || (prg_bank_c000_o == FIXED_BANK))
    else $error("program bank out of range");

endmodule

bind bank_switch_mapper_with_irq_counter bsm_checker u_bsm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .irq_line_o       (irq_line_o),
  .prg_bank_8000_o  (prg_bank_8000_o),
  .prg_bank_c000_o  (prg_bank_c000_o),
  .chr_banks_low_o  (chr_banks_low_o),
  .chr_banks_high_o (chr_banks_high_o)
);

FILE: test/bank_switch_mapper_with_irq_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_irq_counter_tb
// Self-checking bench for the bank switch mapper: a directed table walk, then
// random register programming, irq counter runs and noise, with random gaps
// on the input side and random stalls on the result side. A shadow model of
// the mapper predicts every result word that the directed table does not give.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_irq_counter_tb;
  import bsm_pkg::*;

  localparam int          RAND_ITEMS   = 1950;
  localparam int          DRAIN_CYCLES = 8;
  localparam longint      RUN_LIMIT_NS = 64'd20_000_000;
  localparam logic [3:0]  BELOW_WINDOW = BANK_PRG0 - 4'd1;

  typedef struct packed {
    logic        irq_line;
    logic [4:0]  prg_8000;
    logic [3:0]  prg_a000;
    logic [4:0]  prg_c000;
    logic [31:0] chr_low;
    logic [31:0] chr_high;
    logic [1:0]  mirroring;
  } map_word_t;

  typedef struct packed {
    op_e        op;
    logic [3:0] bank;
    logic [11:0] offset;
    logic [7:0] value;
    logic       typed;
    map_word_t  want;
  } dir_row_t;

  localparam map_word_t MAP_RESET =
    '{1'b0, 5'd0, 4'd1, FIXED_BANK, 32'h03020100, 32'h07060504, 2'd0};
  localparam map_word_t MAP_PRG0_MAX =
    '{1'b0, 5'd15, 4'd1, FIXED_BANK, 32'h03020100, 32'h07060504, 2'd0};
  localparam map_word_t MAP_PRG1_MIN =
    '{1'b0, 5'd15, 4'd0, FIXED_BANK, 32'h03020100, 32'h07060504, 2'd0};
  localparam map_word_t MAP_MIRROR_HI =
    '{1'b0, 5'd15, 4'd0, FIXED_BANK, 32'h03020100, 32'h07060504, 2'd3};
  localparam map_word_t MAP_SWAPPED =
    '{1'b0, FIXED_BANK, 4'd0, 5'd15, 32'h03020100, 32'h07060504, 2'd3};
  localparam map_word_t NO_MAP = '0;

  localparam int DIR_COUNT = 26;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{OP_TICK,  4'h0,               12'h000, 8'h00, 1'b1, MAP_RESET},
    '{OP_WRITE, BELOW_WINDOW,       12'hFFF, 8'hFF, 1'b1, MAP_RESET},
    '{OP_WRITE, BANK_PRG0,          12'h000, 8'hFF, 1'b1, MAP_PRG0_MAX},
    '{OP_WRITE, BANK_PRG1,          12'hF00, 8'hF0, 1'b1, MAP_PRG1_MIN},
    '{OP_WRITE, BANK_MIRROR,        12'h000, 8'h03, 1'b1, MAP_MIRROR_HI},
    '{OP_WRITE, BANK_MIRROR,        12'h002, 8'h02, 1'b1, MAP_SWAPPED},
    '{OP_WRITE, BANK_MIRROR,        12'h040, 8'h01, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_CHR_LO,        12'h000, 8'h0A, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_CHR_LO,        12'h001, 8'h0B, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_CHR_LO + 4'd1, 12'h008, 8'h0C, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_CHR_HI,        12'hFFF, 8'hFF, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_CHR_LO + 4'd2, 12'h080, 8'h05, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h000, 8'hFE, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h010, 8'hFF, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h002, 8'h06, 1'b0, NO_MAP},
    '{OP_TICK,  4'h0,               12'h000, 8'h00, 1'b0, NO_MAP},
    '{OP_TICK,  4'hF,               12'hFFF, 8'hFF, 1'b0, NO_MAP},
    '{OP_TICK,  4'h0,               12'h000, 8'h00, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h003, 8'h00, 1'b0, NO_MAP},
    '{OP_TICK,  4'h0,               12'h000, 8'h00, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h020, 8'h03, 1'b0, NO_MAP},
    '{OP_TICK,  4'h0,               12'h000, 8'h00, 1'b0, NO_MAP},
    '{OP_TICK,  4'h0,               12'h000, 8'h00, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h0C0, 8'hFF, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_IRQ,           12'h002, 8'h00, 1'b0, NO_MAP},
    '{OP_WRITE, BANK_MIRROR,        12'h002, 8'h00, 1'b0, NO_MAP}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [3:0]  bank_i;
  logic [11:0] offset_i;
  logic [7:0]  value_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        irq_line_o;
  logic [4:0]  prg_bank_8000_o;
  logic [3:0]  prg_bank_a000_o;
  logic [4:0]  prg_bank_c000_o;
  logic [31:0] chr_banks_low_o;
  logic [31:0] chr_banks_high_o;
  logic [1:0]  mirroring_o;

  bank_switch_mapper_with_irq_counter u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .bank_i           (bank_i),
    .offset_i         (offset_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .irq_line_o       (irq_line_o),
    .prg_bank_8000_o  (prg_bank_8000_o),
    .prg_bank_a000_o  (prg_bank_a000_o),
    .prg_bank_c000_o  (prg_bank_c000_o),
    .chr_banks_low_o  (chr_banks_low_o),
    .chr_banks_high_o (chr_banks_high_o),
    .mirroring_o      (mirroring_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // shadow copy of the mapper state
  logic [3:0] prg_q [2];
  logic       swap_q;
  logic [1:0] mirror_q;
  logic [7:0] chr_q [NUM_CHR];
  logic [7:0] latch_q;
  logic [7:0] count_q;
  logic [2:0] ctrl_q;
  logic [9:0] presc_q;
  logic       pend_q;

  map_word_t pending_maps [$];
  bit        failed     = 1'b0;
  bit        burst_mode = 1'b0;
  int        items_sent = 0;
  int        stall_left = 0;

  task automatic reset_shadow();
    prg_q[0] = 4'd0;
    prg_q[1] = 4'd1;
    swap_q   = 1'b0;
    mirror_q = 2'd0;
    for (int i = 0; i < NUM_CHR; i++) chr_q[i] = 8'(i);
    latch_q  = 8'd0;
    count_q  = 8'd0;
    ctrl_q   = 3'd0;
    presc_q  = 10'd0;
    pend_q   = 1'b0;
  endtask

  task automatic apply_word(input op_e op, input logic [3:0] bk, input logic [11:0] off,
                            input logic [7:0] val);
    logic [1:0] idx;
    logic [3:0] grp;
    logic [2:0] ent;
    logic       step;
    idx  = off[1:0] | off[3:2] | off[5:4] | off[7:6];
    step = 1'b0;
    if (op == OP_TICK) begin
      if (ctrl_q[CTRL_EN]) begin
        if (ctrl_q[CTRL_CYCLE]) begin
          step = 1'b1;
        end else if (presc_q < PRESCALE_STEP) begin
          presc_q = presc_q + PRESCALE_WRAP;
          step    = 1'b1;
        end else begin
          presc_q = presc_q - PRESCALE_STEP;
        end
        if (step) begin
          if (count_q == COUNTER_MAX) begin
            count_q = latch_q;
            pend_q  = 1'b1;
          end else begin
            count_q = count_q + 8'd1;
          end
        end
      end
    end else begin
      case (bk)
        BANK_PRG0: prg_q[0] = val[3:0];
        BANK_MIRROR: begin
          if (idx[1]) swap_q = val[1];
          else mirror_q = val[1:0];
        end
        BANK_PRG1: prg_q[1] = val[3:0];
        BANK_IRQ: begin
          case (idx)
            IDX_LATCH_LO: latch_q[3:0] = val[3:0];
            IDX_LATCH_HI: latch_q[7:4] = val[3:0];
            IDX_CTRL: begin
              ctrl_q = val[2:0];
              if (ctrl_q[CTRL_EN]) begin
                count_q = latch_q;
                presc_q = PRESCALE_RELOAD;
              end
              pend_q = 1'b0;
            end
            IDX_ACK: begin
              ctrl_q[CTRL_EN] = ctrl_q[CTRL_ACK_EN];
              pend_q = 1'b0;
            end
            default: ;
          endcase
        end
        default: begin
          // character groups, anything below the window is ignored
          if (bk >= BANK_CHR_LO && bk <= BANK_CHR_HI) begin
            grp = bk - BANK_CHR_LO;
            ent = {grp[1:0], idx[1]};
            if (idx[0]) chr_q[ent][7:4] = val[3:0];
            else chr_q[ent][3:0] = val[3:0];
          end
        end
      endcase
    end
  endtask

  function automatic map_word_t mapper_view();
    map_word_t m;
    m.irq_line  = pend_q;
    m.prg_8000  = swap_q ? FIXED_BANK : {1'b0, prg_q[0]};
    m.prg_a000  = prg_q[1];
    m.prg_c000  = swap_q ? {1'b0, prg_q[0]} : FIXED_BANK;
    for (int i = 0; i < 4; i++) begin
      m.chr_low[8*i +: 8]  = chr_q[i];
      m.chr_high[8*i +: 8] = chr_q[i+4];
    end
    m.mirroring = mirror_q;
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // offset whose ored bit pairs give the wanted register index
  function automatic logic [11:0] idx_offset(input logic [1:0] want_idx);
    logic [11:0] o;
    int          p;
    o[11:8] = 4'($urandom);
    for (int k = 0; k < 4; k++) o[2*k +: 2] = 2'($urandom) & want_idx;
    p = $urandom_range(0, 3);
    o[2*p +: 2] = want_idx;
    return o;
  endfunction

  task automatic send_word(input op_e op, input logic [3:0] bk, input logic [11:0] off,
                           input logic [7:0] val, input logic typed, input map_word_t want);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    bank_i     <= bk;
    offset_i   <= off;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_word(op, bk, off, val);
    if (typed) pending_maps.push_back(want);
    else pending_maps.push_back(mapper_view());
    items_sent++;
  endtask

  task automatic rnd_tick();
    send_word(OP_TICK, 4'($urandom), 12'($urandom), 8'($urandom), 1'b0, NO_MAP);
  endtask

  task automatic rnd_write(input logic [3:0] bk, input logic [1:0] idx, input logic [7:0] val);
    logic [11:0] off;
    off = ($urandom_range(0, 99) < 85) ? idx_offset(idx) : 12'($urandom);
    send_word(OP_WRITE, bk, off, val, 1'b0, NO_MAP);
  endtask

  task automatic map_write();
    rnd_write(4'($urandom_range(BANK_PRG0, BANK_CHR_HI)), 2'($urandom), 8'($urandom));
  endtask

  // latch set-up, control write, a run of mostly ticks with some writes mixed in, then usually an acknowledge
  task automatic irq_episode();
    logic [7:0] lo_val;
    logic [7:0] hi_val;
    logic [7:0] ctrl_val;
    int         n;
    int         r;
    lo_val = 8'($urandom);
    if ($urandom_range(0, 1) == 0) lo_val[3:1] = 3'b111;
    hi_val = 8'($urandom);
    if ($urandom_range(0, 3) != 0) hi_val[3:0] = 4'hF;
    ctrl_val = 8'($urandom);
    if ($urandom_range(0, 99) < 80) ctrl_val[CTRL_EN] = 1'b1;
    rnd_write(BANK_IRQ, IDX_LATCH_LO, lo_val);
    rnd_write(BANK_IRQ, IDX_LATCH_HI, hi_val);
    rnd_write(BANK_IRQ, IDX_CTRL, ctrl_val);
    n = ctrl_val[CTRL_CYCLE] ? $urandom_range(1, 40) : $urandom_range(1, 400);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 8) map_write();
      else if (r < 11) rnd_write(BANK_IRQ, IDX_ACK, 8'($urandom));
      else if (r < 13) rnd_write(BANK_IRQ, IDX_CTRL, 8'($urandom));
      else rnd_tick();
    end
    if ($urandom_range(0, 99) < 70) rnd_write(BANK_IRQ, IDX_ACK, 8'($urandom));
  endtask

  task automatic bank_episode();
    int n;
    n = $urandom_range(3, 12);
    repeat (n) begin
      if ($urandom_range(0, 99) < 70) map_write();
      else rnd_tick();
    end
  endtask

  task automatic noise_episode();
    int n;
    n = $urandom_range(2, 10);
    repeat (n) begin
      send_word(op_e'($urandom_range(0, 1)), 4'($urandom), 12'($urandom), 8'($urandom),
                1'b0, NO_MAP);
    end
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    if (burst_mode) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin : result_check
    map_word_t want_m;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_maps.size() == 0) begin
        $error("result word with no expectation waiting");
        failed = 1'b1;
      end else begin
        want_m = pending_maps.pop_front();
        if (irq_line_o !== want_m.irq_line) begin
          $error("irq_line: expected %0d, got %0d", want_m.irq_line, irq_line_o);
          failed = 1'b1;
        end
        if (prg_bank_8000_o !== want_m.prg_8000) begin
          $error("prg_bank_8000: expected %0d, got %0d", want_m.prg_8000, prg_bank_8000_o);
          failed = 1'b1;
        end
        if (prg_bank_a000_o !== want_m.prg_a000) begin
          $error("prg_bank_a000: expected %0d, got %0d", want_m.prg_a000, prg_bank_a000_o);
          failed = 1'b1;
        end
        if (prg_bank_c000_o !== want_m.prg_c000) begin
          $error("prg_bank_c000: expected %0d, got %0d", want_m.prg_c000, prg_bank_c000_o);
          failed = 1'b1;
        end
        if (chr_banks_low_o !== want_m.chr_low) begin
          $error("chr_banks_low: expected %h, got %h", want_m.chr_low, chr_banks_low_o);
          failed = 1'b1;
        end
        if (chr_banks_high_o !== want_m.chr_high) begin
          $error("chr_banks_high: expected %h, got %h", want_m.chr_high, chr_banks_high_o);
          failed = 1'b1;
        end
        if (mirroring_o !== want_m.mirroring) begin
          $error("mirroring: expected %0d, got %0d", want_m.mirroring, mirroring_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int sel;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_TICK;
    bank_i     = 4'd0;
    offset_i   = 12'd0;
    value_i    = 8'd0;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_COUNT; i++) begin
      send_word(DIR_ROWS[i].op, DIR_ROWS[i].bank, DIR_ROWS[i].offset, DIR_ROWS[i].value,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    while (items_sent < RAND_ITEMS) begin
      // some episodes run back to back with no idling on either side
      burst_mode = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 50) irq_episode();
      else if (sel < 85) bank_episode();
      else noise_episode();
    end

    in_valid_i <= 1'b0;
    burst_mode = 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failed) begin
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
